/* rtl/plti_pkg.sv */
// Package for the piecewise-linear time interpolator.
// Holds the sizes, the word and code types and the breakpoint record.
// No dependencies; every other file of the block imports it.
package plti_pkg;

	// Table geometry. Both counts are powers of two, so a table address is
	// the source number followed by the slot number.
	localparam int NUM_SOURCES = 8;
	localparam int MAX_POINTS  = 64;
	localparam int SRC_W       = $clog2(NUM_SOURCES);
	localparam int IDX_W       = $clog2(MAX_POINTS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int ADDR_W      = SRC_W + IDX_W;
	localparam int MEM_DEPTH   = NUM_SOURCES * MAX_POINTS;

	// Field widths.
	localparam int TIME_W = 32;
	localparam int MAG_W  = 24;
	localparam int MAX_W  = 23;
	localparam int STAT_W = 3;

	// The magnitude difference and the quotient carry one bit more than a
	// magnitude; the serial multiply and divide each take one step per bit.
	localparam int DM_W   = MAG_W + 1;
	localparam int STEP_W = $clog2(DM_W);

	typedef logic [TIME_W-1:0]        time_t;
	typedef logic signed [MAG_W-1:0]  mag_t;
	typedef logic [MAX_W-1:0]         max_t;
	typedef logic [SRC_W-1:0]         src_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [ADDR_W-1:0]        addr_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_OUTSIDE  = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_STORED   = 3'd3,
		ST_REJECTED = 3'd4
	} status_t;

	// One stored breakpoint.
	typedef struct packed {
		time_t tm;
		mag_t  mag;
	} point_t;

endpackage

/* rtl/plti_if.sv */
// Handshake channels of the piecewise-linear time interpolator.
// One interface for the input word and one for the result word.
// Depends on plti_pkg for the field types.
interface plti_in_if;
	import plti_pkg::*;

	logic    valid;
	logic    ready;
	logic    opcode;
	src_t    dipole_id;
	idx_t    point_index;
	time_t   point_time;
	mag_t    point_magnitude;
	logic    last_point;
	time_t   query_time;

	modport source (
		output valid, opcode, dipole_id, point_index, point_time,
		       point_magnitude, last_point, query_time,
		input  ready
	);
	modport sink (
		input  valid, opcode, dipole_id, point_index, point_time,
		       point_magnitude, last_point, query_time,
		output ready
	);
endinterface

interface plti_out_if;
	import plti_pkg::*;

	logic                 valid;
	logic                 ready;
	mag_t                 magnitude;
	logic [STAT_W-1:0]    status;
	max_t                 max_magnitude;
	idx_t                 segment_index;

	modport source (
		output valid, magnitude, status, max_magnitude, segment_index,
		input  ready
	);
	modport sink (
		input  valid, magnitude, status, max_magnitude, segment_index,
		output ready
	);
endinterface

/* rtl/piecewise_linear_time_interpolator_core.sv */
// Top level of the piecewise-linear time interpolator.
// Depends on plti_pkg and on the channel interfaces in plti_if.sv.
//
// The block takes one word at a time and answers each with exactly one result
// word. A query on an empty table goes straight to the result register, and a
// load first checks its time against the previous slot. Any other query reads
// the first and last breakpoints; one that misses the time span or hits a
// single-point table is answered there. Otherwise the linear scan reads one
// breakpoint per cycle from the single read port of the breakpoint memory. A
// bit-serial shift-add multiply (25 steps) and a restoring divide (25 steps)
// then share one shift register pair. A query at or past a segment end returns
// that breakpoint directly after the scan, with no multiply or divide. While
// the previous result still waits unaccepted in the output register, a finished
// result holds the block for as long as that stall lasts. A finished result
// waits in the output register while the next word is accepted. The block is
// ready for that word in the cycle right after the result register loads. The
// breakpoint memory is not cleared at reset; a query uses only the slots below
// its table's loaded point count.
module piecewise_linear_time_interpolator_core (
	input  logic      clk,
	input  logic      arst_n,
	plti_in_if.sink   in_ch,
	plti_out_if.source out_ch
);
	import plti_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_LD_CHK  = 10'b0000000010,
		S_Q_FIRST = 10'b0000000100,
		S_Q_LAST  = 10'b0000001000,
		S_SCAN    = 10'b0000010000,
		S_SETUP   = 10'b0000100000,
		S_MUL     = 10'b0001000000,
		S_DIV     = 10'b0010000000,
		S_FIN     = 10'b0100000000,
		S_RES     = 10'b1000000000
	} state_t;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DM_W - 1);

	state_t state_q;
	logic   out_valid_q;
	cnt_t   cnt_q [NUM_SOURCES];
	max_t   max_q;

	// Captured input word.
	src_t   src_q;
	idx_t   idx_q;
	time_t  ptime_q;
	mag_t   pmag_q;
	logic   last_q;
	time_t  qtime_q;
	cnt_t   n_q;

	// Search and arithmetic registers.
	point_t lo_q;
	point_t hi_q;
	idx_t   scan_idx_q;
	logic [TIME_W-1:0] mul_hi_q;
	logic [DM_W-1:0]   mul_lo_q;
	time_t  dt_q;
	time_t  span_q;
	logic   neg_q;
	logic [STEP_W-1:0] step_q;

	// Result staging and output registers.
	mag_t    res_mag_q;
	status_t res_status_q;
	idx_t    res_seg_q;
	mag_t    out_mag_q;
	status_t out_status_q;
	idx_t    out_seg_q;
	max_t    out_max_q;

	// Breakpoint memory with one write and one registered read port.
	point_t pt_mem [MEM_DEPTH];
	point_t rd_q;
	addr_t  rd_addr;
	logic   mem_we;

	logic   in_acc;
	logic   out_free;
	logic   ld_ok;
	logic   q_single;
	logic   q_out;
	logic   scan_go;
	logic   le0;
	logic   ge1;
	cnt_t   n_m1;
	logic [DM_W-1:0]   dm;
	logic [DM_W-1:0]   dm_abs;
	logic [TIME_W:0]   mul_sum;
	logic [TIME_W:0]   div_rem;
	logic              div_ge;
	logic [DM_W-1:0]   quot_s;
	logic [DM_W-1:0]   interp_sum;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// Decisions taken on the word read from the memory in the previous cycle.
	always_comb begin
		n_m1     = n_q - CNT_W'(1);
		ld_ok    = (idx_q == '0) || (ptime_q > rd_q.tm);
		q_single = (n_q == CNT_W'(1));
		q_out    = q_single ? (qtime_q != lo_q.tm)
		                    : ((qtime_q < lo_q.tm) || (qtime_q > rd_q.tm));
		scan_go  = ((CNT_W'(scan_idx_q) + CNT_W'(1)) < n_q) && !(qtime_q < rd_q.tm);
		le0      = (qtime_q <= lo_q.tm);
		ge1      = (qtime_q >= hi_q.tm);
		dm       = {hi_q.mag[MAG_W-1], hi_q.mag} - {lo_q.mag[MAG_W-1], lo_q.mag};
		dm_abs   = dm[DM_W-1] ? (~dm + DM_W'(1)) : dm;
		mul_sum  = {1'b0, mul_hi_q} + (mul_lo_q[0] ? {1'b0, dt_q} : '0);
		div_rem  = {mul_hi_q, mul_lo_q[DM_W-1]};
		div_ge   = (div_rem >= {1'b0, span_q});
		quot_s   = neg_q ? (~mul_lo_q + DM_W'(1)) : mul_lo_q;
		interp_sum = {lo_q.mag[MAG_W-1], lo_q.mag} + quot_s;
	end

	// Read address for the next cycle's memory word.
	always_comb begin
		case (state_q)
			S_IDLE: begin
				if (in_ch.opcode == OP_LOAD)
					rd_addr = {in_ch.dipole_id, in_ch.point_index - IDX_W'(1)};
				else
					rd_addr = {in_ch.dipole_id, IDX_W'(0)};
			end
			S_Q_FIRST: rd_addr = {src_q, n_m1[IDX_W-1:0]};
			S_Q_LAST:  rd_addr = {src_q, IDX_W'(1)};
			S_SCAN:    rd_addr = {src_q, scan_idx_q + IDX_W'(1)};
			default:   rd_addr = {src_q, scan_idx_q};
		endcase
	end

	assign mem_we = (state_q == S_LD_CHK) && ld_ok;

	// Breakpoint memory.
	always_ff @(posedge clk) begin
		if (mem_we)
			pt_mem[{src_q, idx_q}] <= '{tm: ptime_q, mag: pmag_q};
		rd_q <= pt_mem[rd_addr];
	end

	// Sequencer, point counts, running maximum and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			max_q       <= '0;
			for (int i = 0; i < NUM_SOURCES; i++)
				cnt_q[i] <= '0;
		end else begin
			if (state_q == S_RES && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.opcode == OP_LOAD)
							state_q <= S_LD_CHK;
						else if (cnt_q[in_ch.dipole_id] == '0)
							state_q <= S_RES;
						else
							state_q <= S_Q_FIRST;
					end
				end
				S_LD_CHK: begin
					if (ld_ok) begin
						if (last_q)
							cnt_q[src_q] <= CNT_W'(idx_q) + CNT_W'(1);
						if (!pmag_q[MAG_W-1] && (pmag_q[MAX_W-1:0] > max_q))
							max_q <= pmag_q[MAX_W-1:0];
					end
					state_q <= S_RES;
				end
				S_Q_FIRST: state_q <= S_Q_LAST;
				S_Q_LAST: begin
					if (q_single || q_out)
						state_q <= S_RES;
					else
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!scan_go)
						state_q <= S_SETUP;
				end
				S_SETUP: begin
					if (le0 || ge1)
						state_q <= S_RES;
					else
						state_q <= S_MUL;
				end
				S_MUL: begin
					if (step_q == LAST_STEP)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (step_q == LAST_STEP)
						state_q <= S_FIN;
				end
				S_FIN: state_q <= S_RES;
				S_RES: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath: capture, scan, serial multiply and divide, result staging.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					src_q        <= in_ch.dipole_id;
					idx_q        <= in_ch.point_index;
					ptime_q      <= in_ch.point_time;
					pmag_q       <= in_ch.point_magnitude;
					last_q       <= in_ch.last_point;
					qtime_q      <= in_ch.query_time;
					n_q          <= cnt_q[in_ch.dipole_id];
					res_status_q <= ST_EMPTY;
					res_mag_q    <= '0;
					res_seg_q    <= '0;
				end
			end
			S_LD_CHK: begin
				res_status_q <= ld_ok ? ST_STORED : ST_REJECTED;
			end
			S_Q_FIRST: lo_q <= rd_q;
			S_Q_LAST: begin
				// A single point answers only at its exact time.
				res_status_q <= q_out ? ST_OUTSIDE : ST_OK;
				res_mag_q    <= (q_single && !q_out) ? lo_q.mag : '0;
				scan_idx_q   <= IDX_W'(1);
			end
			S_SCAN: begin
				if (scan_go) begin
					lo_q       <= rd_q;
					scan_idx_q <= scan_idx_q + IDX_W'(1);
				end else begin
					hi_q      <= rd_q;
					res_seg_q <= scan_idx_q;
				end
			end
			S_SETUP: begin
				// Query at or past a segment end takes that end's magnitude.
				res_mag_q <= le0 ? lo_q.mag : hi_q.mag;
				mul_hi_q  <= '0;
				mul_lo_q  <= dm_abs;
				neg_q     <= dm[DM_W-1];
				dt_q      <= qtime_q - lo_q.tm;
				span_q    <= hi_q.tm - lo_q.tm;
				step_q    <= '0;
			end
			S_MUL: begin
				// Shift-add: multiplier bits leave the low half as product bits enter.
				mul_hi_q <= mul_sum[TIME_W:1];
				mul_lo_q <= {mul_sum[0], mul_lo_q[DM_W-1:1]};
				step_q   <= (step_q == LAST_STEP) ? '0 : step_q + STEP_W'(1);
			end
			S_DIV: begin
				// Restoring divide; the remainder stays below the span.
				if (div_ge)
					mul_hi_q <= div_rem[TIME_W-1:0] - span_q;
				else
					mul_hi_q <= div_rem[TIME_W-1:0];
				mul_lo_q <= {mul_lo_q[DM_W-2:0], div_ge};
				step_q   <= (step_q == LAST_STEP) ? '0 : step_q + STEP_W'(1);
			end
			S_FIN: res_mag_q <= interp_sum[MAG_W-1:0];
			S_RES: begin
				if (out_free) begin
					out_mag_q    <= res_mag_q;
					out_status_q <= res_status_q;
					out_seg_q    <= res_seg_q;
					out_max_q    <= max_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.magnitude     = out_mag_q;
	assign out_ch.status        = out_status_q;
	assign out_ch.segment_index = out_seg_q;
	assign out_ch.max_magnitude = out_max_q;

endmodule

/* rtl/plti_checker.sv */
// Port-level checks for the piecewise-linear time interpolator.
// Depends on plti_pkg; bound to piecewise_linear_time_interpolator_core below.
module plti_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input plti_pkg::mag_t             magnitude,
	input logic [plti_pkg::STAT_W-1:0] status,
	input plti_pkg::max_t             max_magnitude,
	input plti_pkg::idx_t             segment_index
);
	import plti_pkg::*;

	max_t seen_max_q;

	// Maximum shown on the most recently delivered word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_max_q <= '0;
		else if (out_valid && out_ready)
			seen_max_q <= max_magnitude;
	end

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(magnitude) &&
		$stable(status) && $stable(segment_index) && $stable(max_magnitude)))
		else $error("result word changed while stalled");

	// One word is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice in a row");

	// Only a result with status OK carries a magnitude or a segment.
	a_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (magnitude == '0 && segment_index == '0))
		else $error("nonzero magnitude or segment on a result that is not interpolated");

	// The running maximum never falls.
	a_max_rises: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (max_magnitude >= seen_max_q))
		else $error("running maximum decreased");

endmodule

bind piecewise_linear_time_interpolator_core plti_checker u_plti_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.magnitude     (out_ch.magnitude),
	.status        (out_ch.status),
	.max_magnitude (out_ch.max_magnitude),
	.segment_index (out_ch.segment_index)
);

/* verif/plti_result_checker.sv */
// Result checker for the piecewise-linear time interpolator.
// Watches both channels, predicts every result word and compares it field by field.
// Depends on plti_pkg and on the channel interfaces in plti_if.sv.
`timescale 1ns / 1ps

module plti_result_checker (
	input  logic clk,
	input  logic arst_n,
	plti_in_if   in_mon,
	plti_out_if  out_mon,
	output int   errors,
	output int   pending
);
	import plti_pkg::*;

	typedef struct {
		mag_t    magnitude;
		status_t status;
		max_t    peak;
		idx_t    segment;
	} answer_t;

	// Shadow of the breakpoint tables, the point counts and the running maximum.
	time_t   bp_time [NUM_SOURCES][MAX_POINTS];
	mag_t    bp_mag  [NUM_SOURCES][MAX_POINTS];
	cnt_t    bp_count[NUM_SOURCES];
	max_t    peak_mag;
	answer_t answers_due[$];

	// Linear blend between two breakpoints, quotient truncated toward zero.
	// Segments that are out of order after an overwrite clamp to an end point.
	function automatic mag_t blend(time_t t, time_t t0, time_t t1, mag_t m0, mag_t m1);
		longint dt, span, dm;
		if (t <= t0)
			return m0;
		if (t >= t1)
			return m1;
		dt   = longint'({32'd0, t - t0});
		span = longint'({32'd0, t1 - t0});
		dm   = longint'(m1) - longint'(m0);
		return mag_t'(longint'(m0) + (dt * dm) / span);
	endfunction

	// Applies one accepted word to the shadow state and returns its result word.
	// Source and slot numbers cannot leave their ranges at these field widths.
	function automatic answer_t answer_for(opcode_t op, src_t src, idx_t idx, time_t pt,
			mag_t pm, logic tail, time_t qt);
		answer_t a;
		int      n;
		int      up;
		a.magnitude = '0;
		a.segment   = '0;
		if (op == OP_LOAD) begin
			if (idx != 0 && pt <= bp_time[src][idx - 1]) begin
				a.status = ST_REJECTED;
			end else begin
				bp_time[src][idx] = pt;
				bp_mag[src][idx]  = pm;
				if (tail)
					bp_count[src] = cnt_t'(idx) + 1'b1;
				if (pm > 0 && pm[MAX_W-1:0] > peak_mag)
					peak_mag = pm[MAX_W-1:0];
				a.status = ST_STORED;
			end
		end else if (bp_count[src] == 0) begin
			a.status = ST_EMPTY;
		end else begin
			n = bp_count[src];
			if (n == 1) begin
				// A lone point answers only at its own time.
				if (qt == bp_time[src][0]) begin
					a.magnitude = bp_mag[src][0];
					a.status    = ST_OK;
				end else begin
					a.status = ST_OUTSIDE;
				end
			end else if (qt < bp_time[src][0] || qt > bp_time[src][n - 1]) begin
				a.status = ST_OUTSIDE;
			end else begin
				up = 1;
				while (up < n - 1 && qt >= bp_time[src][up])
					up++;
				a.magnitude = blend(qt, bp_time[src][up - 1], bp_time[src][up],
					bp_mag[src][up - 1], bp_mag[src][up]);
				a.segment   = idx_t'(up);
				a.status    = ST_OK;
			end
		end
		a.peak = peak_mag;
		return a;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Queue a prediction for every accepted input word, take one for every result word.
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			foreach (bp_count[s])
				bp_count[s] = '0;
			peak_mag = '0;
			answers_due.delete();
			errors  = 0;
			pending <= 0;
		end else begin
			if (in_mon.valid && in_mon.ready)
				answers_due.insert(answers_due.size(), answer_for(opcode_t'(in_mon.opcode),
					in_mon.dipole_id, in_mon.point_index, in_mon.point_time,
					in_mon.point_magnitude, in_mon.last_point, in_mon.query_time));
			if (out_mon.valid && out_mon.ready) begin
				if (answers_due.size() == 0) begin
					errors++;
					$display("%0t: result word with nothing expected, magnitude %0d status %0d",
						$time, out_mon.magnitude, out_mon.status);
				end else begin
					want = answers_due.pop_front();
					check_field("magnitude", longint'(want.magnitude),
						longint'(out_mon.magnitude));
					check_field("status", longint'(want.status), longint'(out_mon.status));
					check_field("max_magnitude", longint'(want.peak),
						longint'(out_mon.max_magnitude));
					check_field("segment_index", longint'(want.segment),
						longint'(out_mon.segment_index));
				end
			end
			pending <= answers_due.size();
		end
	end

endmodule

/* verif/tb_piecewise_linear_time_interpolator_core.sv */
// Testbench top for the piecewise-linear time interpolator.
// Drives directed and random load and query words, paces both channels and gives the verdict.
// Depends on plti_pkg, plti_if.sv, the core and plti_result_checker.
`timescale 1ns / 1ps

module tb_piecewise_linear_time_interpolator_core;
	import plti_pkg::*;

	localparam int ITEMS = 1850;

	logic clk = 1'b0;
	logic arst_n;

	plti_in_if  in_ch ();
	plti_out_if out_ch ();

	int mismatches;
	int awaited;

	piecewise_linear_time_interpolator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	plti_result_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_mon  (in_ch),
		.out_mon (out_ch),
		.errors  (mismatches),
		.pending (awaited)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stimulus-side record of which slots hold a time, so that a load never
	// compares against a slot that was never written.
	time_t slot_time[NUM_SOURCES][MAX_POINTS];
	int    filled[NUM_SOURCES];
	int    words_sent;
	int    burst_left;
	int    no_gap_left;
	logic  hold_req;

	// Sends one word, waits for its acceptance and then paces the next one.
	task automatic put_word(opcode_t op, src_t src, idx_t idx, time_t pt, mag_t pm,
			logic tail, time_t qt);
		int gap;
		in_ch.valid           <= 1'b1;
		in_ch.opcode          <= op;
		in_ch.dipole_id       <= src;
		in_ch.point_index     <= idx;
		in_ch.point_time      <= pt;
		in_ch.point_magnitude <= pm;
		in_ch.last_point      <= tail;
		in_ch.query_time      <= qt;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		words_sent++;
		if (op == OP_LOAD && (idx == 0 || pt > slot_time[src][idx - 1])) begin
			slot_time[src][idx] = pt;
			if (filled[src] <= idx)
				filled[src] = idx + 1;
		end
		// Bursts of random length with random gaps; a forced stretch skips gaps.
		if (no_gap_left > 0) begin
			no_gap_left--;
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic put_load(src_t src, idx_t idx, time_t pt, mag_t pm, logic tail);
		put_word(OP_LOAD, src, idx, pt, pm, tail, $urandom);
	endtask

	// The load fields of a query word carry random bits.
	task automatic put_query(src_t src, time_t qt);
		put_word(OP_QUERY, src, idx_t'($urandom), $urandom, mag_t'($urandom),
			$urandom_range(0, 1) == 1, qt);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited != 0);
	endtask

	// Magnitudes widen over the run so the running maximum keeps moving.
	function automatic mag_t pick_magnitude();
		int scale;
		int v;
		scale = 4 + (words_sent * 19) / ITEMS;
		if (scale > MAG_W - 1)
			scale = MAG_W - 1;
		case ($urandom_range(0, 7))
			0: v = -(1 << (MAG_W - 1));
			1: v = 0;
			default: v = int'($urandom_range(0, (1 << (scale + 1)) - 2)) - ((1 << scale) - 1);
		endcase
		return mag_t'(v);
	endfunction

	// Receiver: phases of steady, random, sparse and periodic ready, plus one long hold-off.
	initial begin
		int   mode;
		int   phase_left;
		int   hold_left;
		logic hold_taken;
		phase_left   = 0;
		hold_left    = 0;
		hold_taken   = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (hold_req === 1'b1 && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = 300;
				out_ch.ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					mode       = $urandom_range(0, 3);
					phase_left = $urandom_range(16, 160);
				end
				phase_left--;
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= $urandom_range(0, 1) == 1;
					2: out_ch.ready <= $urandom_range(0, 3) == 0;
					default: out_ch.ready <= (phase_left % 6) < 3;
				endcase
			end
		end
	end

	// A hung block ends the run here.
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		src_t    src;
		int      n;
		int      i;
		int      j;
		int      k;
		int      next_drain;
		longint  step_max;
		longint  room;
		time_t   t;
		time_t   qt;
		time_t   pts[MAX_POINTS];

		words_sent  = 0;
		burst_left  = 0;
		no_gap_left = 0;
		next_drain  = 450;
		foreach (filled[s])
			filled[s] = 0;
		hold_req              <= 1'b0;
		arst_n                <= 1'b0;
		in_ch.valid           <= 1'b0;
		in_ch.opcode          <= OP_LOAD;
		in_ch.dipole_id       <= '0;
		in_ch.point_index     <= '0;
		in_ch.point_time      <= '0;
		in_ch.point_magnitude <= '0;
		in_ch.last_point      <= 1'b0;
		in_ch.query_time      <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty tables, at both ends of the time range.
		put_query(3'd0, 32'd0);
		put_query(3'd7, 32'hFFFF_FFFF);

		// A single-point table answers only at its exact time.
		put_load(3'd1, 6'd0, 32'd100, -24'sd5, 1'b1);
		put_query(3'd1, 32'd100);
		put_query(3'd1, 32'd99);
		put_query(3'd1, 32'd101);

		// Full time span, most negative magnitude, and a rejected equal time.
		put_load(3'd2, 6'd0, 32'd0, {1'b1, {(MAG_W-1){1'b0}}}, 1'b0);
		put_load(3'd2, 6'd1, 32'd0, 24'sd1, 1'b1);
		put_load(3'd2, 6'd1, 32'hFFFF_FFFF, 24'sd1000, 1'b1);
		put_query(3'd2, 32'd0);
		put_query(3'd2, 32'hFFFF_FFFF);
		put_query(3'd2, 32'h8000_0000);

		// Negative slope, truncation toward zero and both edges of the span.
		put_load(3'd3, 6'd0, 32'd10, 24'sd0, 1'b0);
		put_load(3'd3, 6'd1, 32'd13, -24'sd10, 1'b0);
		put_load(3'd3, 6'd2, 32'd20, 24'sd7, 1'b1);
		put_query(3'd3, 32'd11);
		put_query(3'd3, 32'd9);
		put_query(3'd3, 32'd21);

		// Overwriting the first slot leaves the times out of order.
		put_load(3'd3, 6'd0, 32'd15, 24'sd3, 1'b0);
		put_query(3'd3, 32'd15);
		put_query(3'd3, 32'd20);

		// A last flag on a lower slot shrinks the table.
		put_load(3'd3, 6'd1, 32'd16, 24'sd2, 1'b1);
		put_query(3'd3, 32'd20);

		// Random part: mostly well-formed tables followed by probing queries,
		// the rest stray queries, stray or rejected loads and overwrites.
		while (words_sent < ITEMS - 2) begin
			if (words_sent >= next_drain) begin
				drain();
				next_drain += 600;
			end
			if (hold_req !== 1'b1 && words_sent >= 800) begin
				hold_req    <= 1'b1;
				no_gap_left = 48;
			end
			src = src_t'($urandom);
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 15))
					0: n = MAX_POINTS;
					1, 2: n = $urandom_range(9, 24);
					3: n = 1;
					default: n = $urandom_range(2, 8);
				endcase
				case ($urandom_range(0, 3))
					0: step_max = 3;
					1: step_max = 1000;
					2: step_max = 1 << 20;
					default: step_max = 1 << 25;
				endcase
				room = 64'hFFFF_FFFF - longint'(n) * step_max;
				case ($urandom_range(0, 3))
					0: t = '0;
					1: t = time_t'(room);
					default: t = $urandom_range(0, time_t'(room));
				endcase
				for (i = 0; i < n; i++) begin
					if (i > 0) begin
						t += $urandom_range(1, time_t'(step_max));
						// Now and then a load whose time does not advance.
						if ($urandom_range(0, 11) == 0)
							put_load(src, idx_t'(i), ($urandom_range(0, 1) == 1) ?
								pts[i - 1] : $urandom_range(0, pts[i - 1]),
								pick_magnitude(), $urandom_range(0, 1) == 1);
					end
					pts[i] = t;
					put_load(src, idx_t'(i), t, pick_magnitude(),
						i == n - 1 || $urandom_range(0, 7) == 0);
				end
				k = $urandom_range(2, 6);
				repeat (k) begin
					case ($urandom_range(0, 5))
						0: qt = pts[$urandom_range(0, n - 1)];
						1: begin
							j  = (n > 1) ? $urandom_range(0, n - 2) : 0;
							qt = (n > 1) ? $urandom_range(pts[j], pts[j + 1]) : pts[0];
						end
						2: qt = pts[0] - 1'b1;
						3: qt = pts[n - 1] + 1'b1;
						4: qt = $urandom;
						default: qt = pts[n - 1];
					endcase
					put_query(src, qt);
				end
			end else begin
				case ($urandom_range(0, 2))
					0: put_query(src, $urandom);
					1: begin
						// Load at any slot whose predecessor holds a time.
						j = (filled[src] > MAX_POINTS - 1) ? MAX_POINTS - 1 : filled[src];
						i = $urandom_range(0, j);
						if (i > 0 && $urandom_range(0, 1) == 1)
							t = slot_time[src][i - 1] + $urandom_range(0, 2);
						else
							t = $urandom;
						put_load(src, idx_t'(i), t, pick_magnitude(),
							$urandom_range(0, 3) == 0);
					end
					default: begin
						if (filled[src] == 0)
							qt = $urandom;
						else
							qt = slot_time[src][$urandom_range(0, filled[src] - 1)] +
								$urandom_range(0, 2) - 1;
						put_query(src, qt);
					end
				endcase
			end
		end

		// The largest positive magnitude comes last, since it pins the maximum.
		put_load(3'd4, 6'd0, 32'd5, {1'b0, {(MAG_W-1){1'b1}}}, 1'b1);
		put_query(3'd4, 32'd5);

		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
